/* hdl/tds_pkg.sv */
// ----------------------------------------------------------------------------
// Transfer dependency scoreboard package
// Shared sizes, event codes and payload types.
// ----------------------------------------------------------------------------
package tds_pkg;

    localparam int MAX_PENDING = 16;
    localparam int SLOT_W      = $clog2(MAX_PENDING);
    localparam int NODE_W      = 4;
    localparam int SIZE_W      = 32;
    localparam int WAIT_W      = $clog2(MAX_PENDING + 1);

    typedef enum logic [2:0] {
        KIND_QUEUED   = 3'd0,
        KIND_STARTED  = 3'd1,
        KIND_RETIRED  = 3'd2,
        KIND_SKIPPED  = 3'd3,
        KIND_FULL     = 3'd4,
        KIND_BAD_SLOT = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_COMPARE,
        OP_ALLOC,
        OP_RETIRE
    } op_t;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        op_t               op;
        logic [NODE_W-1:0] src;
        logic [NODE_W-1:0] dst;
        logic [SLOT_W-1:0] slot;
    } cell_cmd_t;

    // Status returned from one cell.
    typedef struct packed {
        logic valid;
        logic waiting;
        logic conflict;
        logic waker;
    } cell_stat_t;

    typedef struct packed {
        logic [0:0]        func;
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] dest_node;
        logic [SIZE_W-1:0] transfer_size;
        logic [SLOT_W-1:0] completed_slot;
    } in_item_t;

    typedef struct packed {
        kind_t             event_kind;
        logic [SLOT_W-1:0] slot;
        logic [0:0]        last;
    } out_item_t;

    function automatic logic must_wait(
        input logic [NODE_W-1:0] ns,
        input logic [NODE_W-1:0] nd,
        input logic [NODE_W-1:0] os,
        input logic [NODE_W-1:0] od
    );
        logic new_gg;
        logic old_gg;
        new_gg = (ns != '0) && (nd != '0);
        old_gg = (os != '0) && (od != '0);
        return ((ns == os) && (nd == od)) ||
               (new_gg && (ns == od) && (os == nd)) ||
               (new_gg && (od == ns) && (od == nd)) ||
               (old_gg && (nd == os) && (nd == od));
    endfunction

endpackage

/* hdl/tds_if.sv */
// ----------------------------------------------------------------------------
// Transfer dependency scoreboard channels
// Valid/ready channels for input and result items.
// ----------------------------------------------------------------------------
interface tds_in_if;
    import tds_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tds_out_if;
    import tds_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/tds_cell.sv */
// ----------------------------------------------------------------------------
// Scoreboard cell
// Holds one table slot: endpoints, wait count and its wake row bit chain.
// ----------------------------------------------------------------------------
module tds_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tds_pkg::SLOT_W-1:0]   index,
    input  tds_pkg::cell_cmd_t           cmd,
    input  logic                         link_set,
    input  logic                         dec,
    output tds_pkg::cell_stat_t          stat,
    output logic [tds_pkg::MAX_PENDING-1:0] wake_row,
    output logic                         dec_zero
);
    import tds_pkg::*;

    logic                   valid_reg;
    logic [NODE_W-1:0]      src_reg;
    logic [NODE_W-1:0]      dst_reg;
    logic [WAIT_W-1:0]      wait_reg;
    logic [MAX_PENDING-1:0] row_reg;
    logic                   mine;

    assign mine = (cmd.slot == index);

    // Status towards the sequencer.
    assign stat.valid    = valid_reg;
    assign stat.waiting  = (wait_reg != '0);
    assign stat.conflict = valid_reg && must_wait(cmd.src, cmd.dst, src_reg, dst_reg);
    assign stat.waker    = row_reg[cmd.slot];
    assign wake_row      = row_reg;
    assign dec_zero      = (wait_reg == WAIT_W'(1));

    // Control state of the slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            wait_reg  <= '0;
            row_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_COMPARE:
                begin
                    if (link_set)
                        row_reg[cmd.slot] <= 1'b1;
                end
                OP_ALLOC:
                begin
                    if (mine)
                    begin
                        valid_reg <= 1'b1;
                        row_reg   <= '0;
                        wait_reg  <= '0;
                    end
                    else
                        row_reg[cmd.slot] <= 1'b0;
                end
                OP_RETIRE:
                begin
                    if (mine)
                    begin
                        valid_reg <= 1'b0;
                        row_reg   <= '0;
                        wait_reg  <= '0;
                    end
                    else
                        row_reg[cmd.slot] <= 1'b0;
                end
                default:
                begin
                end
            endcase
            // The new slot counts one blocker for every conflict found.
            if (dec && valid_reg && wait_reg != '0)
                wait_reg <= wait_reg - WAIT_W'(1);
            else if (cmd.op == OP_COMPARE && mine)
                wait_reg <= wait_reg + WAIT_W'(1);
        end
    end

    // Endpoints, written on allocation.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ALLOC && mine)
        begin
            src_reg <= cmd.src;
            dst_reg <= cmd.dst;
        end
    end

endmodule

/* hdl/transfer_dependency_scoreboard_unit.sv */
// ----------------------------------------------------------------------------
// Transfer dependency scoreboard
// Table of pending copy transfers held in a row of cells, one per slot.
// ----------------------------------------------------------------------------
// Submit: allocate the lowest free slot, then compare with each slot in turn,
// one slot per cycle, then emit the result.
// Completion: emit the retired item, then the wake scan visits one slot per
// cycle while no result stalls. Zero size, full table and bad slot give one
// result. One item is worked on at a time. Reset clears all slots at once.
module transfer_dependency_scoreboard_unit (
    input  logic        clk,
    input  logic        rst_n,
    tds_in_if.sink      in_ch,
    tds_out_if.source   out_ch
);
    import tds_pkg::*;

    cell_cmd_t              cmd;
    cell_stat_t             stat [MAX_PENDING];
    logic [MAX_PENDING-1:0] link_set;
    logic [MAX_PENDING-1:0] dec;
    logic [MAX_PENDING-1:0] dec_zero;
    logic [MAX_PENDING-1:0] rows [MAX_PENDING];
    logic [MAX_PENDING-1:0] valid_vec;

    state_t            state_reg, state_next;
    logic              func_reg, func_next;
    logic [NODE_W-1:0] src_reg, src_next;
    logic [NODE_W-1:0] dst_reg, dst_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              any_reg, any_next;
    logic              done_reg, done_next;
    logic              ov_reg, ov_next;
    out_item_t         od_reg, od_next;
    logic [MAX_PENDING-1:0] wrow_reg, wrow_next;
    logic [SLOT_W-1:0] free_slot;
    logic              has_free;
    logic              scan_hit;
    logic [MAX_PENDING-1:0] start_vec;
    logic              later_start;

    // Row of slot cells.
    for (genvar g = 0; g < MAX_PENDING; g++)
    begin : g_cell
        tds_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .index    (SLOT_W'(g)),
            .cmd      (cmd),
            .link_set (link_set[g]),
            .dec      (dec[g]),
            .stat     (stat[g]),
            .wake_row (rows[g]),
            .dec_zero (dec_zero[g])
        );
        assign valid_vec[g] = stat[g].valid;
    end

    // Lowest free slot.
    always_comb
    begin
        free_slot = '0;
        has_free  = 1'b0;
        for (int i = MAX_PENDING - 1; i >= 0; i--)
        begin
            if (!valid_vec[i])
            begin
                free_slot = SLOT_W'(i);
                has_free  = 1'b1;
            end
        end
    end

    assign scan_hit = wrow_reg[idx_reg] && (idx_reg != slot_reg) &&
                      stat[idx_reg].valid && stat[idx_reg].waiting;

    // Slots that the retirement will start, and whether any lies beyond the scan point.
    always_comb
    begin
        later_start = 1'b0;
        for (int j = 0; j < MAX_PENDING; j++)
        begin
            start_vec[j] = wrow_reg[j] && (SLOT_W'(j) != slot_reg) && stat[j].valid &&
                           stat[j].waiting && dec_zero[j];
            if ((SLOT_W'(j) > idx_reg) && start_vec[j])
                later_start = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        src_reg  <= src_next;
        dst_reg  <= dst_next;
        slot_reg <= slot_next;
        idx_reg  <= idx_next;
        any_reg  <= any_next;
        done_reg <= done_next;
        od_reg   <= od_next;
        wrow_reg <= wrow_next;
    end

    assign in_ch.ready  = (state_reg == ST_IDLE) && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        func_next  = func_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        slot_next  = slot_reg;
        idx_next   = idx_reg;
        any_next   = any_reg;
        done_next  = done_reg;
        wrow_next  = wrow_reg;
        od_next    = od_reg;
        ov_next    = ov_reg && !out_ch.ready;
        cmd.op     = OP_NONE;
        cmd.src    = src_reg;
        cmd.dst    = dst_reg;
        cmd.slot   = slot_reg;
        link_set   = '0;
        dec        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    func_next = in_ch.data.func;
                    src_next  = in_ch.data.source_node;
                    dst_next  = in_ch.data.dest_node;
                    idx_next  = '0;
                    any_next  = 1'b0;
                    if (in_ch.data.func == 1'b0)
                    begin
                        if (in_ch.data.transfer_size == '0)
                        begin
                            od_next = '{KIND_SKIPPED, '0, 1'b1};
                            ov_next = 1'b1;
                        end
                        else if (!has_free)
                        begin
                            od_next = '{KIND_FULL, '0, 1'b1};
                            ov_next = 1'b1;
                        end
                        else
                        begin
                            // Allocate first so that stale links of the slot are
                            // cleared before the new ones are set.
                            cmd.op     = OP_ALLOC;
                            cmd.slot   = free_slot;
                            cmd.src    = in_ch.data.source_node;
                            cmd.dst    = in_ch.data.dest_node;
                            slot_next  = free_slot;
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        slot_next = in_ch.data.completed_slot;
                        if (!stat[in_ch.data.completed_slot].valid ||
                            stat[in_ch.data.completed_slot].waiting)
                        begin
                            od_next = '{KIND_BAD_SLOT, in_ch.data.completed_slot, 1'b1};
                            ov_next = 1'b1;
                        end
                        else
                        begin
                            wrow_next = rows[in_ch.data.completed_slot];
                            od_next   = '{KIND_RETIRED, in_ch.data.completed_slot, 1'b0};
                            done_next = 1'b0;
                            state_next = ST_EMIT;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // Submit: compare with slot idx, one per cycle.
                if (stat[idx_reg].conflict && idx_reg != slot_reg)
                begin
                    cmd.op = OP_COMPARE;
                    link_set[idx_reg] = 1'b1;
                    any_next = 1'b1;
                end
                if (idx_reg == SLOT_W'(MAX_PENDING - 1))
                    state_next = ST_EMIT;
                else
                    idx_next = idx_reg + SLOT_W'(1);
            end
            ST_EMIT:
            begin
                if (func_reg == 1'b0)
                begin
                    if (!ov_reg)
                    begin
                        od_next = '{any_reg ? KIND_QUEUED : KIND_STARTED, slot_reg, 1'b1};
                        ov_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (!ov_reg || out_ch.ready)
                begin
                    // Completion: walk slots, one per cycle while no result stalls, emitting starts.
                    if (!done_reg)
                    begin
                        // The retired item is last when nothing will start.
                        od_next = od_reg;
                        od_next.last = !(|start_vec);
                        ov_next = 1'b1;
                        done_next = 1'b1;
                        idx_next = '0;
                    end
                    else
                    begin
                        ov_next = 1'b0;
                        if (scan_hit)
                            dec[idx_reg] = 1'b1;
                        if (scan_hit && dec_zero[idx_reg])
                        begin
                            od_next = '{KIND_STARTED, idx_reg, !later_start};
                            ov_next = 1'b1;
                        end
                        if (idx_reg == SLOT_W'(MAX_PENDING - 1))
                        begin
                            cmd.op = OP_RETIRE;
                            state_next = ST_IDLE;
                        end
                        else
                            idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/tds_checker.sv */
// ----------------------------------------------------------------------------
// Scoreboard port checker
// Watches the ports of the top level over time.
// ----------------------------------------------------------------------------
module tds_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [2:0] out_kind
);
    import tds_pkg::*;

    // A stalled result item holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // Kinds stay in range.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_kind <= 3'd5)
        else $error("bad event kind");

    // No input is taken while a result waits.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result waits");

endmodule

bind transfer_dependency_scoreboard_unit tds_checker u_tds_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.data.event_kind)
);
